FILE: rtl/bpfl_pkg.sv
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types and constants for the buffer pool free list allocator.
// ----------------------------------------------------------------------------
package bpfl_pkg;

  // Pool size and derived widths
  localparam int NUM_BUFFERS = 16;
  localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);

  // Fixed widths of the item fields
  localparam int BUF_FIELD_W = 4;
  localparam int CNT_FIELD_W = 5;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_EXHAUSTED  = 2'd1,
    ERR_NOT_IN_USE = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  typedef logic [IDX_W-1:0] idx_t;

  // Link store access: read addresses plus one write port per chain memory
  typedef struct packed {
    idx_t free_rd_addr;
    idx_t used_rd_addr;
    logic un_we;
    idx_t un_waddr;
    idx_t un_wdata;
    logic up_we;
    idx_t up_waddr;
    idx_t up_wdata;
    logic fn_we;
    idx_t fn_waddr;
    idx_t fn_wdata;
  } link_req_t;

  typedef struct packed {
    idx_t free_next;
    idx_t used_next;
    idx_t used_prev;
  } link_rsp_t;

endpackage

FILE: rtl/bpfl_ram.sv
// ----------------------------------------------------------------------------
// bpfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpfl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bpfl_links.sv
// ----------------------------------------------------------------------------
// bpfl_links
// Link memories of the two chains: used next, used previous and free next.
// The free chain starts in index order; per-entry valid bits stand in for
// that initial content until an entry is written.
// ----------------------------------------------------------------------------
module bpfl_links (
  input  logic                 clk,
  input  logic                 rst,
  input  bpfl_pkg::link_req_t  req,
  output bpfl_pkg::link_rsp_t  rsp
);

  import bpfl_pkg::*;

  logic [NUM_BUFFERS-1:0] fn_valid;
  logic                   fn_valid_q;
  idx_t                   fn_dflt_q;
  idx_t                   fn_rdata;
  idx_t                   un_rdata;
  idx_t                   up_rdata;

  bpfl_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_used_next (
    .clk   (clk),
    .we    (req.un_we),
    .waddr (req.un_waddr),
    .wdata (req.un_wdata),
    .raddr (req.used_rd_addr),
    .rdata (un_rdata)
  );

  bpfl_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_used_prev (
    .clk   (clk),
    .we    (req.up_we),
    .waddr (req.up_waddr),
    .wdata (req.up_wdata),
    .raddr (req.used_rd_addr),
    .rdata (up_rdata)
  );

  bpfl_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_free_next (
    .clk   (clk),
    .we    (req.fn_we),
    .waddr (req.fn_waddr),
    .wdata (req.fn_wdata),
    .raddr (req.free_rd_addr),
    .rdata (fn_rdata)
  );

  // Mark free links once written
  always_ff @(posedge clk) begin
    if (rst) begin
      fn_valid <= '0;
    end else if (req.fn_we) begin
      fn_valid[req.fn_waddr] <= 1'b1;
    end
  end

  // Track the reset-order link alongside the RAM read
  always_ff @(posedge clk) begin
    fn_valid_q <= fn_valid[req.free_rd_addr];
    fn_dflt_q  <= (req.free_rd_addr == IDX_W'(NUM_BUFFERS - 1)) ? '0
                : req.free_rd_addr + IDX_W'(1);
  end

  always_comb begin
    rsp.free_next = fn_valid_q ? fn_rdata : fn_dflt_q;
    rsp.used_next = un_rdata;
    rsp.used_prev = up_rdata;
  end

endmodule

FILE: rtl/buffer_pool_free_list_allocator.sv
// ----------------------------------------------------------------------------
// buffer_pool_free_list_allocator
// Free list buffer allocator over a pool of NUM_BUFFERS buffers.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready): opcode 0 allocates the head of the
//   free chain, opcode 1 releases buffer_index from the in-use chain.
//   Result channel (out_valid/out_ready): one item per request with ok,
//   granted_index, error_code, used_count, chain_empty and first_used.
//   A request is taken only while the sequencer is idle. It then presents
//   addresses to the link memories in its lookup step and, in its commit
//   step, uses the registered read data to update the chains and load the
//   result register. Each request passes through the idle step that takes
//   it, then the registered read of the link memories and their write-back,
//   before the next request can be taken.
//   A finished result waits in the output register while the next request
//   is accepted and looked up; that request holds in its commit step until
//   the result register is free, so a stalled receiver stalls the block.
//   Reset empties the in-use chain, puts every buffer on the free chain in
//   index order and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module buffer_pool_free_list_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [bpfl_pkg::BUF_FIELD_W-1:0]    buffer_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                ok,
  output logic [bpfl_pkg::BUF_FIELD_W-1:0]    granted_index,
  output bpfl_pkg::err_code_t                 error_code,
  output logic [bpfl_pkg::CNT_FIELD_W-1:0]    used_count,
  output logic                                chain_empty,
  output logic [bpfl_pkg::BUF_FIELD_W-1:0]    first_used
);

  import bpfl_pkg::*;

  state_t                 state;
  state_t                 state_next;
  opcode_t                op_r;
  idx_t                   idx_r;
  logic                   in_range_r;
  logic [NUM_BUFFERS-1:0] in_use_flags;
  idx_t                   used_head;
  idx_t                   used_tail;
  idx_t                   free_head;
  idx_t                   free_tail;
  logic [CNT_W-1:0]       in_use_count;

  idx_t                   used_head_next;
  idx_t                   used_tail_next;
  idx_t                   free_head_next;
  idx_t                   free_tail_next;
  logic [CNT_W-1:0]       in_use_count_next;

  link_req_t              link_req;
  link_rsp_t              link_rsp;

  logic                   accept;
  logic                   commit_fire;
  logic                   slot_free;
  logic                   pool_full;
  logic                   alloc_ok;
  logic                   rel_ok;
  logic                   is_head;
  logic                   is_tail;
  err_code_t              err;
  idx_t                   granted;

  bpfl_links u_links (
    .clk (clk),
    .rst (rst),
    .req (link_req),
    .rsp (link_rsp)
  );

  assign slot_free = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign pool_full = (in_use_count == CNT_W'(NUM_BUFFERS));
  assign alloc_ok  = (op_r == OP_ALLOC) && !pool_full;
  assign rel_ok    = (op_r == OP_RELEASE) && in_range_r && in_use_flags[idx_r]
                     && (in_use_count != '0);
  assign is_head   = (idx_r == used_head);
  assign is_tail   = (idx_r == used_tail);

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_COMMIT;
      ST_COMMIT: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    commit_fire = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_LOOKUP: ;
      ST_COMMIT: commit_fire = slot_free;
      default:   ;
    endcase
  end

  // Chain updates and link writes for the committing request
  always_comb begin
    used_head_next    = used_head;
    used_tail_next    = used_tail;
    free_head_next    = free_head;
    free_tail_next    = free_tail;
    in_use_count_next = in_use_count;
    err               = ERR_NONE;
    granted           = '0;

    link_req              = '0;
    link_req.free_rd_addr = free_head;
    link_req.used_rd_addr = idx_r;

    if (op_r == OP_ALLOC) begin
      if (alloc_ok) begin
        granted        = free_head;
        free_head_next = link_rsp.free_next;
        if (in_use_count == '0) begin
          used_head_next = free_head;
        end else begin
          link_req.un_we    = commit_fire;
          link_req.un_waddr = used_tail;
          link_req.un_wdata = free_head;
          link_req.up_we    = commit_fire;
          link_req.up_waddr = free_head;
          link_req.up_wdata = used_tail;
        end
        used_tail_next    = free_head;
        in_use_count_next = in_use_count + CNT_W'(1);
      end else begin
        err = ERR_EXHAUSTED;
      end
    end else begin
      if (rel_ok) begin
        granted = idx_r;
        // Unlink from the in-use chain
        if (is_head) begin
          used_head_next = link_rsp.used_next;
        end else begin
          link_req.un_we    = commit_fire;
          link_req.un_waddr = link_rsp.used_prev;
          link_req.un_wdata = link_rsp.used_next;
        end
        if (is_tail) begin
          // Keep the tail when the chain drains; its value is unused then
          if (!is_head) begin
            used_tail_next = link_rsp.used_prev;
          end
        end else begin
          link_req.up_we    = commit_fire;
          link_req.up_waddr = link_rsp.used_next;
          link_req.up_wdata = link_rsp.used_prev;
        end
        // Append to the free chain
        if (pool_full) begin
          free_head_next = idx_r;
        end else begin
          link_req.fn_we    = commit_fire;
          link_req.fn_waddr = free_tail;
          link_req.fn_wdata = idx_r;
        end
        free_tail_next    = idx_r;
        in_use_count_next = in_use_count - CNT_W'(1);
      end else begin
        err = ERR_NOT_IN_USE;
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request under work
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= opcode_t'(opcode);
      idx_r      <= IDX_W'(buffer_index);
      in_range_r <= (32'(buffer_index) < NUM_BUFFERS);
    end
  end

  // Chain heads, tails, count and in-use flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use_flags <= '0;
      used_head    <= '0;
      used_tail    <= '0;
      free_head    <= '0;
      free_tail    <= IDX_W'(NUM_BUFFERS - 1);
      in_use_count <= '0;
    end else if (commit_fire) begin
      used_head    <= used_head_next;
      used_tail    <= used_tail_next;
      free_head    <= free_head_next;
      free_tail    <= free_tail_next;
      in_use_count <= in_use_count_next;
      if (alloc_ok) begin
        in_use_flags[free_head] <= 1'b1;
      end else if (rel_ok) begin
        in_use_flags[idx_r] <= 1'b0;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (commit_fire) begin
      ok            <= (err == ERR_NONE);
      granted_index <= BUF_FIELD_W'(granted);
      error_code    <= err;
      used_count    <= CNT_FIELD_W'(in_use_count_next);
      chain_empty   <= (in_use_count_next == '0);
      first_used    <= (in_use_count_next == '0) ? '0 : BUF_FIELD_W'(used_head_next);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_use_count <= CNT_W'(NUM_BUFFERS))
    else $error("in-use count beyond pool size");

  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    (commit_fire && alloc_ok) |=> in_use_flags[$past(free_head)])
    else $error("allocated buffer not marked in use");

  a_error_keeps: assert property (@(posedge clk) disable iff (rst)
    (commit_fire && !alloc_ok && !rel_ok) |=> (in_use_count == $past(in_use_count)))
    else $error("failed request changed the in-use count");

  a_ok_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (error_code == ERR_NONE)))
    else $error("ok and error code disagree");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chain_empty == (used_count == '0)))
    else $error("chain empty flag disagrees with count");

endmodule
